// ----- hdl/assert_macros.svh -----
// assertion macros used by the rtl file sorted_unique_set_table.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion of a property, checked on every rising clock edge out of reset
`define SUT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// next-cycle implication
`define SUT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/sutab_pkg.sv -----
// package for the sorted unique set table: sizes, codes and cell control
package sutab_pkg;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CNT_W       = $clog2(CAPACITY + 1);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]              count_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_CHECK  = 2'd2,
    OP_SPARE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_DUP  = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_e;

  typedef struct packed {
    logic ins;
    logic ers;
  } cell_ctrl_t;

endpackage

// ----- hdl/sutab_cell.sv -----
// one compare-and-shift cell of the sorted table
module sutab_cell
  import sutab_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  value_t     key_i,
  input  logic       lt_left_i,
  input  value_t     entry_left_i,
  input  logic       valid_left_i,
  input  value_t     entry_right_i,
  input  logic       valid_right_i,
  output logic       lt_o,
  output logic       eq_o,
  output value_t     entry_o,
  output logic       valid_o
);

  value_t entry_q, entry_d;
  logic   valid_q, valid_d;

  assign lt_o    = valid_q && (entry_q < key_i);
  assign eq_o    = valid_q && (entry_q == key_i);
  assign entry_o = entry_q;
  assign valid_o = valid_q;

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    if (ctrl_i.ins && !lt_o) begin
      if (lt_left_i) begin
        entry_d = key_i;
        valid_d = 1'b1;
      end else begin
        entry_d = entry_left_i;
        valid_d = valid_left_i;
      end
    end else if (ctrl_i.ers && !lt_o) begin
      entry_d = entry_right_i;
      valid_d = valid_right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ----- hdl/sorted_unique_set_table.sv -----
// Sorted unique set table: holds up to 16 distinct signed 32-bit values in
// ascending order in a row of compare-and-shift cells. Each word (opcode and
// value) is taken when start_i is high; busy_o stays low, so a new word may
// follow every cycle. The result appears with done_o in the cycle after the
// word is taken and is shown for that single cycle only, as the receiver
// cannot stall; it must be captured then. All cells compare against the value
// at once, so the cells update at the same clock edge that registers the result.
`include "assert_macros.svh"

module sorted_unique_set_table
  import sutab_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] key_value_i,
  output logic        done_o,
  output logic        was_present_o,
  output logic [1:0]  status_o,
  output logic [4:0]  entry_count_o
);

  value_t               key;
  logic [CAPACITY:0]    lt_chain;
  value_t               entry_chain [CAPACITY+1];
  logic [CAPACITY:0]    valid_chain;
  logic [CAPACITY-1:0]  eq_vec;
  logic                 found;
  logic                 full;
  op_e                  op;
  cell_ctrl_t           ctrl;
  status_e              status_d;
  count_t               count_q, count_d;
  logic                 done_q;
  logic                 present_q;
  status_e              status_q;
  logic [CNT_W+4:0]     count_ext;

  assign key  = value_t'(key_value_i);
  assign op   = op_e'(opcode_i);
  assign found = |eq_vec;
  assign full  = valid_chain[CAPACITY-1];

  assign lt_chain[0]           = 1'b1;
  assign entry_chain[CAPACITY] = '0;
  assign valid_chain[CAPACITY] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    value_t left_entry;
    logic   left_valid;
    if (i == 0) begin : g_head
      assign left_entry = '0;
      assign left_valid = 1'b0;
    end else begin : g_body
      assign left_entry = entry_chain[i-1];
      assign left_valid = valid_chain[i-1];
    end
    sutab_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .key_i         (key),
      .lt_left_i     (lt_chain[i]),
      .entry_left_i  (left_entry),
      .valid_left_i  (left_valid),
      .entry_right_i (entry_chain[i+1]),
      .valid_right_i (valid_chain[i+1]),
      .lt_o          (lt_chain[i+1]),
      .eq_o          (eq_vec[i]),
      .entry_o       (entry_chain[i]),
      .valid_o       (valid_chain[i])
    );
  end

  always_comb begin
    ctrl     = '0;
    count_d  = count_q;
    status_d = found ? ST_DONE : ST_MISS;
    unique case (op)
      OP_INSERT: begin
        if (found) begin
          status_d = ST_DUP;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.ins = start_i;
          count_d  = count_q + count_t'(1);
          status_d = ST_DONE;
        end
      end
      OP_ERASE: begin
        if (found) begin
          ctrl.ers = start_i;
          count_d  = count_q - count_t'(1);
        end
      end
      OP_CHECK, OP_SPARE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= start_i;
      if (start_i) begin
        count_q <= count_d;
      end
    end
  end

  // result word
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      present_q <= found;
      status_q  <= status_d;
    end
  end

  // update never stalls, so busy is tied low
  assign busy_o        = 1'b0;
  assign done_o        = done_q;
  assign was_present_o = present_q;
  assign status_o      = status_q;
  assign count_ext     = {5'b0, count_q};
  assign entry_count_o = count_ext[4:0];

  `SUT_ASSERT(a_count_bound, count_q <= count_t'(CAPACITY), "entry count above capacity")
  `SUT_ASSERT(a_valid_thermo, $countones(valid_chain) == int'(count_q), "valid cells and count differ")
  `SUT_ASSERT_NEXT(a_strobe, start_i, done_o, "result strobe missing after start")
  `SUT_ASSERT(a_full_status, !(done_o && status_o == ST_FULL) || count_q == count_t'(CAPACITY), "full status with free space")

endmodule

// ----- verif/set_table_checker.sv -----
// checker for the sorted set table: predicts each result and compares it with the block
module set_table_checker
  import sutab_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] key_value_i,
  input  logic        done_i,
  input  logic        was_present_i,
  input  logic [1:0]  status_i,
  input  logic [4:0]  entry_count_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic       was_present;
    status_e    status;
    logic [4:0] entry_count;
  } set_outcome_t;

  value_t       set_vals [CAPACITY];
  int unsigned  set_len;
  set_outcome_t outcome_q [$];
  int           fails;

  function automatic set_outcome_t apply_set_op(op_e op, value_t key);
    set_outcome_t res;
    int unsigned  pos;
    int unsigned  i;
    logic         hit;
    pos = 0;
    while (pos < set_len && set_vals[pos] < key) pos++;
    hit = (pos < set_len) && (set_vals[pos] == key);
    case (op)
      OP_INSERT: begin
        if (hit) begin
          res.status = ST_DUP;
        end else if (set_len >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (i = set_len; i > pos; i--) set_vals[i] = set_vals[i-1];
          set_vals[pos] = key;
          set_len++;
          res.status = ST_DONE;
        end
      end
      OP_ERASE: begin
        if (hit) begin
          for (i = pos; i + 1 < set_len; i++) set_vals[i] = set_vals[i+1];
          set_len--;
          res.status = ST_DONE;
        end else begin
          res.status = ST_MISS;
        end
      end
      default: res.status = hit ? ST_DONE : ST_MISS;
    endcase
    res.was_present = hit;
    res.entry_count = set_len[4:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    set_outcome_t want;
    if (!rst_ni) begin
      set_len = 0;
      outcome_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (done_i) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result word: was_present %0b status %0d count %0d",
                   $time, was_present_i, status_i, entry_count_i);
          fails++;
        end else begin
          want = outcome_q.pop_front();
          if (was_present_i !== want.was_present) begin
            $display("%0t: was_present expected %0b actual %0b",
                     $time, want.was_present, was_present_i);
            fails++;
          end
          if (status_i !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_i);
            fails++;
          end
          if (entry_count_i !== want.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d",
                     $time, want.entry_count, entry_count_i);
            fails++;
          end
        end
      end
      if (start_i && !busy_i) begin
        outcome_q.push_back(apply_set_op(op_e'(opcode_i), value_t'(key_value_i)));
      end
      fail_count_o <= fails;
      pending_o <= outcome_q.size();
    end
  end

endmodule

// ----- verif/tb.sv -----
// testbench top for the sorted set table: reset, clock, word stimulus and verdict
module tb
  import sutab_pkg::*;
();

  localparam value_t KEY_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam value_t KEY_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam int     POOL_SIZE = 32;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [1:0]  opcode_i;
  logic [31:0] key_value_i;
  logic        done_o;
  logic        was_present_o;
  logic [1:0]  status_o;
  logic [4:0]  entry_count_o;

  int     fail_count;
  int     pending;
  int     idle_pct;
  int     words_sent;
  value_t key_pool [POOL_SIZE];

  sorted_unique_set_table uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .opcode_i      (opcode_i),
    .key_value_i   (key_value_i),
    .done_o        (done_o),
    .was_present_o (was_present_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  set_table_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .opcode_i      (opcode_i),
    .key_value_i   (key_value_i),
    .done_i        (done_o),
    .was_present_i (was_present_o),
    .status_i      (status_o),
    .entry_count_i (entry_count_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

  task automatic send_word(input op_e op, input value_t key);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      opcode_i <= 2'($urandom);
      key_value_i <= $urandom;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    opcode_i <= op;
    key_value_i <= key;
    do @(posedge clk_i); while (busy_o);
    words_sent++;
  endtask

  task automatic wait_quiet();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic run_directed();
    int i;
    send_word(OP_CHECK, '0);
    send_word(OP_ERASE, value_t'(7));
    send_word(OP_INSERT, KEY_MAX);
    send_word(OP_INSERT, KEY_MIN);
    send_word(OP_INSERT, '0);
    send_word(OP_INSERT, value_t'(-1));
    send_word(OP_INSERT, '0);
    send_word(OP_SPARE, value_t'(-1));
    send_word(OP_SPARE, value_t'(3));
    send_word(OP_ERASE, value_t'(3));
    // fill up to capacity
    for (i = 1; i <= 12; i++) send_word(OP_INSERT, value_t'(i > 9 ? i - 20 : i));
    send_word(OP_INSERT, value_t'(100));
    send_word(OP_INSERT, value_t'(5));
    send_word(OP_ERASE, KEY_MIN);
    send_word(OP_ERASE, KEY_MAX);
    send_word(OP_ERASE, value_t'(4));
  endtask

  // mixed traffic over the key pool, then erase every pool key to empty the table
  task automatic run_round(input int n);
    int     ins_w;
    int     ers_w;
    int     r;
    int     i;
    int     first;
    int     stride;
    logic   fresh;
    value_t key;
    op_e    op;
    for (i = 24; i < POOL_SIZE; i++) key_pool[i] = value_t'($urandom);
    ins_w = $urandom_range(25, 65);
    ers_w = $urandom_range(15, 40);
    for (i = 0; i < n; i++) begin
      fresh = ($urandom_range(99) < 12);
      key = fresh ? value_t'($urandom) : key_pool[$urandom_range(POOL_SIZE-1)];
      r = $urandom_range(99);
      if (r < 3) op = OP_SPARE;
      else if (r < 3 + ins_w) op = fresh ? OP_CHECK : OP_INSERT;
      else if (r < 3 + ins_w + ers_w) op = OP_ERASE;
      else op = OP_CHECK;
      send_word(op, key);
    end
    first = $urandom_range(POOL_SIZE-1);
    stride = 2 * $urandom_range(15) + 1;
    for (i = 0; i < POOL_SIZE; i++) begin
      send_word(OP_ERASE, key_pool[(first + i * stride) % POOL_SIZE]);
    end
  endtask

  initial begin
    int ph;
    int i;
    rst_ni = 1'b0;
    start_i = 1'b0;
    opcode_i = OP_CHECK;
    key_value_i = '0;
    idle_pct = 11;
    words_sent = 0;
    for (i = 0; i < 20; i++) key_pool[i] = value_t'(i - 10);
    key_pool[20] = KEY_MIN;
    key_pool[21] = KEY_MAX;
    key_pool[22] = KEY_MIN + 1;
    key_pool[23] = KEY_MAX - 1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    for (ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 11 : (ph == 1) ? 49 : 0;
      while (words_sent < (ph + 1) * 567) run_round($urandom_range(60, 140));
      wait_quiet();
    end
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
